>>> sv/afba_pkg.sv
// ----------------------------------------------------------------------------
// afba_pkg: shared types and constants for the block allocator
// Status codes, field widths and the cell-to-cell handoff record.
// ----------------------------------------------------------------------------
`default_nettype none
package afba_pkg;
	localparam int unsigned MaxBlocksDef = 16;
	localparam logic [31:0] MinBlockReset = 32'd1048576;
	localparam int unsigned SizeW = 32;
	localparam int unsigned AlignW = 17;
	localparam int unsigned IdxW = 4;
	localparam int unsigned StatW = 2;

	typedef enum logic [StatW-1:0] {
		ST_PLACED = 2'd0,
		ST_NEW    = 2'd1,
		ST_FULL   = 2'd2
	} status_t;

	// request travelling down the chain of cells
	typedef struct packed {
		logic              vld;
		logic              done;
		logic [SizeW-1:0]  size;
		logic [AlignW-1:0] align;
		logic [SizeW-1:0]  off;
	} tok_t;
endpackage
`default_nettype wire

>>> sv/afba_cell.sv
// ----------------------------------------------------------------------------
// afba_cell: one table entry of the allocator chain
// Holds capacity and fill of one block. An unplaced token at a used block sits
// for a rounding pass (one remainder bit per cycle); all go to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none
module afba_cell (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire afba_pkg::tok_t tok_in,
	input  wire logic           in_used,
	input  wire logic           alloc_new,
	input  wire logic [31:0]    new_cap,
	input  wire logic [31:0]    new_fill,
	output afba_pkg::tok_t      tok_out,
	output logic                busy
);
	import afba_pkg::*;

	typedef enum logic [2:0] {
		C_IDLE = 3'b001,
		C_DIV  = 3'b010,
		C_PASS = 3'b100
	} cst_t;

	cst_t           st_q;
	tok_t           tok_q;
	logic [31:0]    cap_q, fill_q;
	logic [32:0]    rem_q;
	logic [5:0]     bit_q;
	logic           used_q;
	logic [33:0]    rem_sh;
	logic [33:0]    off_w;
	logic [31:0]    ali;
	logic           fits;

	assign ali = (tok_q.align == '0) ? 32'd1 : {15'd0, tok_q.align};
	assign rem_sh = {rem_q, fill_q[5'(bit_q)]};
	// aligned offset once the remainder is known
	assign off_w = (rem_q == '0) ? {2'd0, fill_q} :
		{2'd0, fill_q} + {2'd0, ali} - {1'b0, rem_q};
	assign fits = used_q && (cap_q >= tok_q.size) && (off_w <= {2'd0, cap_q}) &&
		({2'd0, cap_q} - off_w >= {2'd0, tok_q.size});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= C_IDLE;
			tok_q <= '0;
			rem_q <= '0;
			bit_q <= '0;
			used_q <= 1'b0;
		end else begin
			if (alloc_new) used_q <= 1'b1;
			case (st_q)
				C_IDLE: begin
					tok_q.vld <= 1'b0;
					if (tok_in.vld) begin
						tok_q.done <= tok_in.done;
						tok_q.size <= tok_in.size;
						tok_q.align <= tok_in.align;
						tok_q.off <= tok_in.off;
						rem_q <= '0;
						bit_q <= 6'd31;
						st_q <= (tok_in.done || !in_used) ? C_PASS : C_DIV;
					end
				end
				C_DIV: begin
					// restoring remainder step, MSB first
					rem_q <= (rem_sh >= {2'd0, ali}) ? 33'(rem_sh - {2'd0, ali}) :
						rem_sh[32:0];
					if (bit_q == 6'd0) st_q <= C_PASS;
					else bit_q <= bit_q - 6'd1;
				end
				C_PASS: begin
					st_q <= C_IDLE;
					tok_q.vld <= 1'b1;
					if (!tok_q.done && fits) begin
						tok_q.done <= 1'b1;
						tok_q.off <= off_w[31:0];
					end
				end
				default: st_q <= C_IDLE;
			endcase
		end
	end

	// block contents: new block written in place, fill bumped on a placement
	always_ff @(posedge clk) begin
		if (alloc_new) begin
			cap_q <= new_cap;
			fill_q <= new_fill;
		end else if (st_q == C_PASS && !tok_q.done && fits) begin
			fill_q <= 32'(off_w + {2'd0, tok_q.size});
		end
	end

	assign tok_out = tok_q;
	assign busy = (st_q != C_IDLE) || tok_q.vld;
endmodule
`default_nettype wire

>>> sv/aligned_first_fit_block_allocator.sv
// ----------------------------------------------------------------------------
// aligned_first_fit_block_allocator: first-fit bump allocator with alignment
// Chain of per-block cells; the request visits each used block in order.
// ----------------------------------------------------------------------------
// Search: each used block searched takes capture, a 32-step remainder and
//   handoff; every other cell only captures and hands off.
// Throughput: one request at a time; next beat taken the cycle after the result leaves.
// Reset: block count zero, min_block_size 1048576, table contents undefined.
`default_nettype none
module aligned_first_fit_block_allocator #(
	parameter int unsigned MAX_BLOCKS = afba_pkg::MaxBlocksDef
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [31:0] cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [31:0] request_size,
	input  wire logic [16:0] alignment,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [3:0]       block_index,
	output logic [31:0]      offset,
	output logic [1:0]       status
);
	import afba_pkg::*;

	localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);
	localparam int unsigned PW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

	tok_t              chain [MAX_BLOCKS+1];
	tok_t              tail;
	logic [MAX_BLOCKS-1:0] busy, used, alloc;
	logic [CW-1:0]     count_q;
	logic [31:0]       min_q;
	logic              act_q;
	logic [PW-1:0]     hit_q;
	logic              accept;
	logic [31:0]       ncap;

	assign accept = in_valid && !in_stall;
	assign in_stall = act_q || out_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) min_q <= MinBlockReset;
		else if (cfg_we) min_q <= cfg_wdata;
	end

	// launch token into cell 0
	assign chain[0].vld = accept;
	assign chain[0].done = 1'b0;
	assign chain[0].size = request_size;
	assign chain[0].align = alignment;
	assign chain[0].off = '0;

	assign tail = chain[MAX_BLOCKS];
	// capacity of an appended block
	assign ncap = (tail.size > min_q) ? tail.size : min_q;

	for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
		assign used[g] = (count_q > CW'(g));
		assign alloc[g] = act_q && tail.vld && !tail.done && (count_q == CW'(g));
		afba_cell u_cell (
			.clk(clk), .arst_n(arst_n), .tok_in(chain[g]), .in_used(used[g]),
			.alloc_new(alloc[g]), .new_cap(ncap), .new_fill(tail.size),
			.tok_out(chain[g+1]), .busy(busy[g])
		);
	end

	// result from chain end; record which cell placed it
	logic [PW-1:0] hit_w;
	always_comb begin
		hit_w = hit_q;
		for (int i = MAX_BLOCKS - 1; i >= 0; i--)
			if (chain[i+1].vld && chain[i+1].done && !chain[i].done) hit_w = PW'(i);
	end

	logic [31:0] tail_off_q;
	logic [1:0]  st_q;
	logic [3:0]  idx_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
			out_valid <= 1'b0;
			count_q <= '0;
			hit_q <= '0;
			st_q <= ST_PLACED;
			idx_q <= '0;
			tail_off_q <= '0;
		end else begin
			if (accept) begin
				act_q <= 1'b1;
				hit_q <= '0;
			end else if (act_q) begin
				hit_q <= hit_w;
			end
			if (act_q && tail.vld) begin
				act_q <= 1'b0;
				out_valid <= 1'b1;
				if (tail.done) begin
					st_q <= ST_PLACED;
					idx_q <= 4'(hit_w);
					tail_off_q <= tail.off;
				end else if (count_q < CW'(MAX_BLOCKS)) begin
					st_q <= ST_NEW;
					idx_q <= 4'(count_q);
					tail_off_q <= '0;
					count_q <= count_q + 1'b1;
				end else begin
					st_q <= ST_FULL;
					idx_q <= '0;
					tail_off_q <= '0;
				end
			end else if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	assign block_index = idx_q;
	assign offset = tail_off_q;
	assign status = st_q;

	// stalled result beat holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable({block_index, offset, status}));
	// no new beat while a request is walking the chain
	a_in_block: assert property (@(posedge clk) disable iff (!arst_n)
		act_q |-> in_stall);
	// chain is quiet between requests
	a_idle_chain: assert property (@(posedge clk) disable iff (!arst_n)
		!act_q |-> busy == '0);
	// only defined status codes leave
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_PLACED) || (status == ST_NEW) || (status == ST_FULL));
	// block count never passes the table size
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_BLOCKS));
endmodule
`default_nettype wire

>>> bench/aligned_first_fit_block_allocator_tb.sv
// ----------------------------------------------------------------------------
// aligned_first_fit_block_allocator_tb: self-checking bench for the allocator
// Drives allocation requests with bursty timing and random output stalls, and
// predicts each result from a behavioral copy of the block table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module aligned_first_fit_block_allocator_tb;
	import afba_pkg::*;

	localparam int NBLK = int'(MaxBlocksDef);
	localparam int WDOG_LIMIT = 20000;

	typedef struct packed {
		logic [3:0]  idx;
		logic [31:0] off;
		status_t     st;
	} alloc_t;

	// predictor plus queue of expected allocations
	class alloc_scoreboard;
		logic [31:0] min_size;
		logic [31:0] cap[NBLK];
		logic [31:0] fill[NBLK];
		int          count;
		alloc_t      pending[$];
		int          errors;

		function void clear();
			min_size = MinBlockReset;
			count = 0;
			pending.delete();
			errors = 0;
		endfunction

		function void note_request(logic [31:0] size, logic [16:0] align);
			logic [63:0] a, o, r;
			alloc_t res;
			a = (align == 0) ? 64'd1 : {47'd0, align};
			for (int i = 0; i < count; i++) begin
				if (cap[i] < size)
					continue;
				r = {32'd0, fill[i]} % a;
				o = (r != 0) ? {32'd0, fill[i]} + a - r : {32'd0, fill[i]};
				if (o > cap[i] || {32'd0, cap[i]} - o < size)
					continue;
				fill[i] = o[31:0] + size;
				res = '{idx: i[3:0], off: o[31:0], st: ST_PLACED};
				pending.push_back(res);
				return;
			end
			if (count < NBLK) begin
				cap[count] = (size > min_size) ? size : min_size;
				fill[count] = size;
				res = '{idx: count[3:0], off: 32'd0, st: ST_NEW};
				count++;
			end else
				res = '{idx: 4'd0, off: 32'd0, st: ST_FULL};
			pending.push_back(res);
		endfunction

		function void check_result(logic [3:0] idx, logic [31:0] off, logic [1:0] st);
			alloc_t e;
			if (pending.size() == 0) begin
				$error("unexpected result beat idx=%0d off=%0h status=%0d", idx, off, st);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (idx !== e.idx) begin
				$error("block_index exp %0d got %0d", e.idx, idx);
				errors++;
			end
			if (off !== e.off) begin
				$error("offset exp %0h got %0h", e.off, off);
				errors++;
			end
			if (st !== e.st) begin
				$error("status exp %0d got %0d", e.st, st);
				errors++;
			end
		endfunction
	endclass

	logic clk, arst_n, cfg_we, in_valid, out_stall;
	logic [31:0] cfg_wdata, request_size;
	logic [16:0] alignment;
	logic in_stall, out_valid;
	logic [3:0] block_index;
	logic [31:0] offset;
	logic [1:0] status;

	alloc_scoreboard sb;
	int idle_cycles;
	int stall_mode;

	aligned_first_fit_block_allocator dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall), .request_size(request_size),
		.alignment(alignment), .out_valid(out_valid), .out_stall(out_stall),
		.block_index(block_index), .offset(offset), .status(status)
	);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	// receiver: stall pattern changes mode now and then
	always @(posedge clk) begin
		if (out_valid && !out_stall && arst_n)
			sb.check_result(block_index, offset, status);
		if ($urandom_range(0, 63) == 0)
			stall_mode <= $urandom_range(0, 3);
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			2: out_stall <= ($urandom_range(0, 1) == 0);
			default: out_stall <= ($urandom_range(0, 9) != 0);
		endcase
	end

	// watchdog on cycles with no beat on either side
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic send_request(logic [31:0] size, logic [16:0] align);
		request_size <= size;
		alignment <= align;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_request(size, align);
	endtask

	task automatic gap();
		in_valid <= 1'b0;
		repeat ($urandom_range(1, 12)) @(posedge clk);
	endtask

	// block must be idle: wait until all results are back, plus latency
	task automatic write_min_size(logic [31:0] v);
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.min_size = v;
	endtask

	function automatic logic [16:0] rand_align();
		case ($urandom_range(0, 5))
			0: return 17'd1 << $urandom_range(0, 16);
			1: return 17'($urandom_range(0, 17'h1ffff));
			2: return 17'($urandom_range(1, 16));
			default: return 17'd1 << $urandom_range(0, 6);
		endcase
	endfunction

	function automatic logic [31:0] rand_size();
		case ($urandom_range(0, 7))
			0: return $urandom();
			1: return 32'd0;
			2: return $urandom_range(0, 4096);
			default: return $urandom_range(1, 300);
		endcase
	endfunction

	task automatic random_phase(int n);
		int left, burst;
		left = n;
		while (left > 0) begin
			burst = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
			for (int i = 0; i < burst && left > 0; i++, left--)
				send_request(rand_size(), rand_align());
			gap();
		end
	endtask

	initial begin
		logic [31:0] min_sizes[5];
		sb = new();
		sb.clear();
		stall_mode = 0;
		idle_cycles = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		out_stall = 1'b0;
		request_size = '0;
		alignment = 17'd1;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset min size, edge sizes and alignments, table fill
		send_request(32'd0, 17'd0);
		send_request(32'd5, 17'd1);
		send_request(32'd3, 17'd8);
		send_request(32'hffff_ffff, 17'h1ffff);
		send_request(32'd1, 17'h1ffff);
		send_request(32'd1, 17'd65536);
		send_request(32'd1048576, 17'd4);
		send_request(32'd100, 17'd3);
		gap();
		write_min_size(32'd0);
		send_request(32'd0, 17'd1);
		send_request(32'd0, 17'd2);
		send_request(32'd7, 17'd16);
		for (int i = 0; i < 12; i++)
			send_request(32'h8000_0000 + i, 17'd1);

		// random phases over several min sizes, table full by the end
		min_sizes = '{32'd1, 32'hffff_ffff, 32'd256, 32'd4096, 32'd1048576};
		foreach (min_sizes[k]) begin
			write_min_size(32'd0);
			write_min_size(min_sizes[k]);
			random_phase(250);
		end

		in_valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (600) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule

>>> sim.f
sv/afba_pkg.sv
sv/afba_cell.sv
sv/aligned_first_fit_block_allocator.sv
bench/aligned_first_fit_block_allocator_tb.sv
